// ===== rtl/tcr_pkg.sv =====
// Package for the touch coordinate remapper.
// Holds field widths, configuration register indexes, mode codes and reset values.
// No dependencies.
package tcr_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int DIM_BITS       = 12;
	localparam int ID_BITS        = 5;
	localparam int ACT_BITS       = 2;
	localparam int MODE_BITS      = 2;
	localparam int CFG_IDX_BITS   = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_SWAP_MODE     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_HEIGHT = 3'd4;

	// swap_mode codes
	localparam logic [MODE_BITS-1:0] MODE_SCALE     = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_ROTATE    = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_SWAP      = 2'd2;
	localparam logic [MODE_BITS-1:0] MODE_SCALE_ALT = 2'd3;

	// reset values
	localparam logic [DIM_BITS-1:0] RST_SOURCE_WIDTH  = 12'd1920;
	localparam logic [DIM_BITS-1:0] RST_SOURCE_HEIGHT = 12'd1080;
	localparam logic [DIM_BITS-1:0] RST_TARGET_WIDTH  = 12'd2376;
	localparam logic [DIM_BITS-1:0] RST_TARGET_HEIGHT = 12'd1080;

endpackage

// ===== rtl/touch_coordinate_remapper.sv =====
// Touch coordinate remapper: top level, multiply stage, bit-per-stage divider and clamp.
// Depends on tcr_pkg.
//
// Usage: one touch event enters on the input channel (in_valid / in_stall) as a
// transaction carrying pointer_id, raw_x, raw_y and touch_action. One result
// leaves on the output channel (out_valid / out_stall) with the same id and
// action and the remapped coordinates. Transactions leave in the order taken.
// The pipeline has one multiply stage, one range-check stage, one restoring-divide
// stage per quotient bit, and the clamp/output register. Throughput is one
// transaction per cycle while out_stall holds no valid result; the divider is
// fully unrolled into pipeline stages, so nothing iterates.
// When out_stall holds a valid result, the whole pipeline freezes and in_stall
// rises in the same cycle; nothing is dropped or repeated.
// Reset empties the pipeline and loads the configuration defaults (mode 0,
// source 1920x1080, target 2376x1080). The user must write configuration through
// cfg_write / cfg_index / cfg_data only while no transaction is in flight; the block does not enforce this.
module touch_coordinate_remapper #(
	parameter int COORD_BITS = tcr_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [tcr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [tcr_pkg::DIM_BITS-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [tcr_pkg::ID_BITS-1:0]       pointer_id,
	input  logic [COORD_BITS-1:0]             raw_x,
	input  logic [COORD_BITS-1:0]             raw_y,
	input  logic [tcr_pkg::ACT_BITS-1:0]      touch_action,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tcr_pkg::ID_BITS-1:0]       out_pointer_id,
	output logic [COORD_BITS-1:0]             remap_x,
	output logic [COORD_BITS-1:0]             remap_y,
	output logic [tcr_pkg::ACT_BITS-1:0]      out_action
);

	localparam int CB    = COORD_BITS;
	localparam int DB    = tcr_pkg::DIM_BITS;
	localparam int NUM_W = CB + DB;
	localparam int EXT_W = ((CB > DB) ? CB : DB) + 1;
	localparam logic [CB-1:0] COORD_MAX = {CB{1'b1}};

	typedef struct packed {
		logic [tcr_pkg::ID_BITS-1:0]  id;
		logic [tcr_pkg::ACT_BITS-1:0] act;
		logic [CB-1:0]                x;
		logic [CB-1:0]                y;
	} meta_t;

	typedef struct packed {
		logic [DB-1:0] rem;
		logic [CB-1:0] low;
		logic [CB-1:0] quot;
		logic          ovf;
		logic [DB-1:0] dvs;
	} lane_t;

	function automatic lane_t div_init(logic [NUM_W-1:0] num, logic [DB-1:0] dvs);
		lane_t r;
		r.rem  = num[NUM_W-1:CB];
		r.low  = num[CB-1:0];
		r.quot = '0;
		r.ovf  = (num[NUM_W-1:CB] >= dvs);
		r.dvs  = dvs;
		return r;
	endfunction

	function automatic lane_t div_step(lane_t l);
		lane_t         r;
		logic [DB:0]   t;
		logic          ge;
		r  = l;
		t  = {l.rem, l.low[CB-1]};
		ge = (t >= {1'b0, l.dvs});
		r.rem  = ge ? DB'(t - {1'b0, l.dvs}) : t[DB-1:0];
		r.low  = {l.low[CB-2:0], 1'b0};
		r.quot = {l.quot[CB-2:0], ge};
		return r;
	endfunction

	function automatic logic [CB-1:0] div_result(lane_t l);
		return l.ovf ? COORD_MAX : l.quot;
	endfunction

	// configuration
	logic [tcr_pkg::MODE_BITS-1:0] swap_mode_q;
	logic [DB-1:0] source_width_q, source_height_q, target_width_q, target_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_mode_q     <= tcr_pkg::MODE_SCALE;
			source_width_q  <= tcr_pkg::RST_SOURCE_WIDTH;
			source_height_q <= tcr_pkg::RST_SOURCE_HEIGHT;
			target_width_q  <= tcr_pkg::RST_TARGET_WIDTH;
			target_height_q <= tcr_pkg::RST_TARGET_HEIGHT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tcr_pkg::REG_SWAP_MODE:     swap_mode_q <= cfg_data[tcr_pkg::MODE_BITS-1:0];
				tcr_pkg::REG_SOURCE_WIDTH:  source_width_q  <= cfg_data;
				tcr_pkg::REG_SOURCE_HEIGHT: source_height_q <= cfg_data;
				tcr_pkg::REG_TARGET_WIDTH:  target_width_q  <= cfg_data;
				tcr_pkg::REG_TARGET_HEIGHT: target_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: pipeline moves unless a held result is stalled
	logic adv;
	logic out_valid_q;
	assign adv       = !(out_valid_q && out_stall);
	assign in_stall  = !adv;
	assign out_valid = out_valid_q;

	// stage 1: operand select and multiply
	logic             rot;
	logic [CB-1:0]    mul_a_op, mul_b_op;
	logic [DB-1:0]    div_a_sel, div_b_sel;

	assign rot       = (swap_mode_q == tcr_pkg::MODE_ROTATE);
	assign mul_a_op  = rot ? raw_y : raw_x;
	assign mul_b_op  = rot ? raw_x : raw_y;
	assign div_a_sel = rot ? source_height_q : source_width_q;
	assign div_b_sel = rot ? source_width_q : source_height_q;

	logic             valid_s1;
	meta_t            meta_s1;
	logic [NUM_W-1:0] num_a_s1, num_b_s1;
	logic [DB-1:0]    div_a_s1, div_b_s1;

	// divider stages 0 .. CB
	logic  vld_s  [0:CB];
	meta_t meta_s [0:CB];
	lane_t lane_a_s [0:CB];
	lane_t lane_b_s [0:CB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i <= CB; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			valid_s1 <= in_valid;
			vld_s[0] <= valid_s1;
			for (int i = 1; i <= CB; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			out_valid_q <= vld_s[CB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1.id  <= pointer_id;
			meta_s1.act <= touch_action;
			meta_s1.x   <= raw_x;
			meta_s1.y   <= raw_y;
			num_a_s1    <= NUM_W'(mul_a_op) * NUM_W'(target_width_q);
			num_b_s1    <= NUM_W'(mul_b_op) * NUM_W'(target_height_q);
			div_a_s1    <= div_a_sel;
			div_b_s1    <= div_b_sel;

			meta_s[0]   <= meta_s1;
			lane_a_s[0] <= div_init(num_a_s1, div_a_s1);
			lane_b_s[0] <= div_init(num_b_s1, div_b_s1);
			for (int i = 1; i <= CB; i++) begin
				meta_s[i]   <= meta_s[i-1];
				lane_a_s[i] <= div_step(lane_a_s[i-1]);
				lane_b_s[i] <= div_step(lane_b_s[i-1]);
			end
		end
	end

	// output stage: mode select and clamp
	logic [CB-1:0]    qa, qb;
	logic [EXT_W-1:0] tw_ext, qa_ext, diff;
	logic [CB-1:0]    rot_x, mx_nxt, my_nxt;

	assign qa     = div_result(lane_a_s[CB]);
	assign qb     = div_result(lane_b_s[CB]);
	assign tw_ext = EXT_W'(target_width_q);
	assign qa_ext = EXT_W'(qa);
	assign diff   = tw_ext - qa_ext;

	always_comb begin
		if (tw_ext < qa_ext) begin
			rot_x = '0;
		end else if (diff > EXT_W'(COORD_MAX)) begin
			rot_x = COORD_MAX;
		end else begin
			rot_x = diff[CB-1:0];
		end
	end

	always_comb begin
		unique case (swap_mode_q)
			tcr_pkg::MODE_ROTATE: begin
				mx_nxt = rot_x;
				my_nxt = qb;
			end
			tcr_pkg::MODE_SWAP: begin
				mx_nxt = meta_s[CB].y;
				my_nxt = meta_s[CB].x;
			end
			default: begin
				mx_nxt = qa;
				my_nxt = qb;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_pointer_id <= meta_s[CB].id;
			out_action     <= meta_s[CB].act;
			remap_x        <= mx_nxt;
			remap_y        <= my_nxt;
		end
	end

endmodule

// ===== test/touch_remap_checker.sv =====
`timescale 1ns / 1ps
// Checker for the touch coordinate remapper: watches the config port and both channels,
// predicts each remapped event and compares results in order. Depends on tcr_pkg.
module touch_remap_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [tcr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [tcr_pkg::DIM_BITS-1:0]      cfg_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [tcr_pkg::ID_BITS-1:0]       pointer_id,
	input  logic [tcr_pkg::COORD_BITS_DEF-1:0] raw_x,
	input  logic [tcr_pkg::COORD_BITS_DEF-1:0] raw_y,
	input  logic [tcr_pkg::ACT_BITS-1:0]      touch_action,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [tcr_pkg::ID_BITS-1:0]       out_pointer_id,
	input  logic [tcr_pkg::COORD_BITS_DEF-1:0] remap_x,
	input  logic [tcr_pkg::COORD_BITS_DEF-1:0] remap_y,
	input  logic [tcr_pkg::ACT_BITS-1:0]      out_action,
	output int                                errors,
	output int                                pending
);
	import tcr_pkg::*;

	localparam int     CB        = COORD_BITS_DEF;
	localparam longint COORD_TOP = (longint'(1) << CB) - 1;

	typedef struct packed {
		logic [ID_BITS-1:0]  id;
		logic [CB-1:0]       x;
		logic [CB-1:0]       y;
		logic [ACT_BITS-1:0] act;
	} touch_result_t;

	logic [MODE_BITS-1:0] mode_q;
	logic [DIM_BITS-1:0]  src_w, src_h, dst_w, dst_h;
	touch_result_t        expected_q[$];
	int                   accepted_cnt, delivered_cnt;

	assign pending = accepted_cnt - delivered_cnt;

	// coord * mul / div, truncated; a zero divisor saturates
	function automatic longint ratio(longint coord, longint mul, longint div);
		if (div == 0) return COORD_TOP;
		return coord * mul / div;
	endfunction

	function automatic logic [CB-1:0] clamp_coord(longint v);
		if (v < 0) return '0;
		if (v > COORD_TOP) return '1;
		return v[CB-1:0];
	endfunction

	function automatic touch_result_t remap_touch(logic [ID_BITS-1:0] id, logic [CB-1:0] x,
		logic [CB-1:0] y, logic [ACT_BITS-1:0] act);
		longint       mx, my;
		touch_result_t r;
		case (mode_q)
			MODE_ROTATE: begin
				mx = longint'(dst_w) - ratio(y, dst_w, src_h);
				my = ratio(x, dst_h, src_w);
			end
			MODE_SWAP: begin
				mx = y;
				my = x;
			end
			default: begin
				mx = ratio(x, dst_w, src_w);
				my = ratio(y, dst_h, src_h);
			end
		endcase
		r.id  = id;
		r.x   = clamp_coord(mx);
		r.y   = clamp_coord(my);
		r.act = act;
		return r;
	endfunction

	function automatic int field_bad(string name, logic [15:0] want, logic [15:0] got);
		if (want === got) return 0;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		touch_result_t want;
		int            bad;
		if (!arst_n) begin
			mode_q        <= MODE_SCALE;
			src_w         <= RST_SOURCE_WIDTH;
			src_h         <= RST_SOURCE_HEIGHT;
			dst_w         <= RST_TARGET_WIDTH;
			dst_h         <= RST_TARGET_HEIGHT;
			accepted_cnt  <= 0;
			delivered_cnt <= 0;
			errors        <= 0;
			expected_q.delete();
		end else begin
			bad = 0;
			if (cfg_write) begin
				case (cfg_index)
					REG_SWAP_MODE:     mode_q <= cfg_data[MODE_BITS-1:0];
					REG_SOURCE_WIDTH:  src_w  <= cfg_data;
					REG_SOURCE_HEIGHT: src_h  <= cfg_data;
					REG_TARGET_WIDTH:  dst_w  <= cfg_data;
					REG_TARGET_HEIGHT: dst_h  <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				delivered_cnt <= delivered_cnt + 1;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, actual id %0d x %0d y %0d",
						$time, out_pointer_id, remap_x, remap_y);
					bad = 1;
				end else begin
					want = expected_q.pop_front();
					bad += field_bad("out_pointer_id", want.id, out_pointer_id);
					bad += field_bad("remap_x", want.x, remap_x);
					bad += field_bad("remap_y", want.y, remap_y);
					bad += field_bad("out_action", want.act, out_action);
				end
			end
			if (in_valid && !in_stall) begin
				expected_q.push_back(remap_touch(pointer_id, raw_x, raw_y, touch_action));
				accepted_cnt <= accepted_cnt + 1;
			end
			errors <= errors + bad;
		end
	end

endmodule

// ===== test/tb_touch_coordinate_remapper.sv =====
`timescale 1ns / 1ps
// Testbench top for touch_coordinate_remapper: clock, reset, config phases, touch stimulus with
// random idling on both channels, and the verdict. Depends on tcr_pkg, the remapper and touch_remap_checker.
module tb_touch_coordinate_remapper;
	import tcr_pkg::*;

	localparam int CB          = COORD_BITS_DEF;
	localparam int LATENCY     = CB + 3;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [CB-1:0] COORD_MAX = '1;
	localparam logic [DIM_BITS-1:0] DIM_MAX = '1;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_write;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [DIM_BITS-1:0]     cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic [ID_BITS-1:0]      pointer_id;
	logic [CB-1:0]           raw_x, raw_y;
	logic [ACT_BITS-1:0]     touch_action;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [ID_BITS-1:0]      out_pointer_id;
	logic [CB-1:0]           remap_x, remap_y;
	logic [ACT_BITS-1:0]     out_action;

	int errors, pending;
	int cycle_count = 0;
	int sink_wait = 0;
	int events_sent = 0;
	int settings_used = 1;
	bit calm = 1'b1;

	touch_coordinate_remapper #(.COORD_BITS(CB)) u_top (.*);

	touch_remap_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d transactions outstanding", cycle_count, pending);
			$display("FAIL touch_coordinate_remapper");
			$finish;
		end
	end

	// result side: after each taken transaction, hold out_stall for a random wait unless the phase is calm
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sink_wait = calm ? 0 : $urandom_range(0, 8);
		else if (sink_wait > 0)
			sink_wait--;
		out_stall <= (sink_wait != 0);
	end

	task automatic send_event(logic [ID_BITS-1:0] id, logic [CB-1:0] x, logic [CB-1:0] y,
		logic [ACT_BITS-1:0] act);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		pointer_id   <= id;
		raw_x        <= x;
		raw_y        <= y;
		touch_action <= act;
		do @(posedge clk); while (in_stall);
		events_sent++;
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// writes all five registers plus one stray index past the list
	task automatic set_config(logic [MODE_BITS-1:0] mode, logic [DIM_BITS-1:0] sw,
		logic [DIM_BITS-1:0] sh, logic [DIM_BITS-1:0] tw, logic [DIM_BITS-1:0] th);
		cfg_write <= 1'b1;
		cfg_index <= REG_SWAP_MODE;
		cfg_data  <= {(DIM_BITS-MODE_BITS)'($urandom), mode};
		@(posedge clk);
		cfg_index <= REG_SOURCE_WIDTH;
		cfg_data  <= sw;
		@(posedge clk);
		cfg_index <= REG_SOURCE_HEIGHT;
		cfg_data  <= sh;
		@(posedge clk);
		cfg_index <= REG_TARGET_WIDTH;
		cfg_data  <= tw;
		@(posedge clk);
		cfg_index <= REG_TARGET_HEIGHT;
		cfg_data  <= th;
		@(posedge clk);
		cfg_index <= REG_TARGET_HEIGHT + CFG_IDX_BITS'($urandom_range(1, 3));
		cfg_data  <= DIM_BITS'($urandom);
		@(posedge clk);
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	// all four corners, every action code, both id extremes
	task automatic send_corners();
		for (int k = 0; k < 4; k++)
			send_event(k[0] ? '1 : '0, k[0] ? COORD_MAX : '0, k[1] ? COORD_MAX : '0,
				ACT_BITS'(k));
	endtask

	function automatic logic [DIM_BITS-1:0] pick_dim();
		case ($urandom_range(0, 11))
			0: return DIM_BITS'(1);
			1: return DIM_MAX;
			2: return ($urandom_range(0, 2) == 0) ? '0 : DIM_BITS'($urandom_range(1, 16));
			default: return DIM_BITS'($urandom_range(1, DIM_MAX));
		endcase
	endfunction

	function automatic logic [CB-1:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return COORD_MAX;
			default: return CB'($urandom);
		endcase
	endfunction

	initial begin
		arst_n       <= 1'b0;
		cfg_write    <= 1'b0;
		cfg_index    <= REG_SWAP_MODE;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		pointer_id   <= '0;
		raw_x        <= '0;
		raw_y        <= '0;
		touch_action <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings first (x overflows and clamps high)
		send_corners();
		drain_pipeline();
		set_config(MODE_ROTATE, RST_SOURCE_WIDTH, RST_SOURCE_HEIGHT, RST_TARGET_WIDTH,
			RST_TARGET_HEIGHT);
		send_corners();
		drain_pipeline();
		set_config(MODE_SWAP, DIM_BITS'(640), DIM_BITS'(480), DIM_BITS'(800), DIM_BITS'(600));
		send_corners();
		drain_pipeline();
		set_config(MODE_SCALE_ALT, DIM_BITS'(1), DIM_BITS'(1), DIM_BITS'(1), DIM_BITS'(1));
		send_corners();
		drain_pipeline();
		set_config(MODE_ROTATE, '0, '0, DIM_MAX, DIM_MAX);
		send_corners();
		drain_pipeline();
		set_config(MODE_SCALE, '0, DIM_MAX, DIM_BITS'(1), DIM_MAX);
		send_corners();

		// random phases; every third one runs without idling
		for (int phase = 0; phase < 8; phase++) begin
			drain_pipeline();
			calm = 1'b0;
			set_config(MODE_BITS'($urandom_range(0, 3)), pick_dim(), pick_dim(), pick_dim(),
				pick_dim());
			calm = (phase % 3 == 2);
			for (int i = 0; i < 50; i++) begin
				if (phase == 3 && i == 25)
					drain_pipeline();
				send_event(ID_BITS'($urandom), pick_coord(), pick_coord(), ACT_BITS'($urandom));
			end
		end
		drain_pipeline();

		$display("Sent %0d touch transactions under %0d register settings: all modes,", events_sent,
			settings_used);
		$display("zero and full-size surfaces, clamping at both ends, random stalls on both sides.");
		if (errors == 0 && pending == 0)
			$display("PASS touch_coordinate_remapper");
		else
			$display("FAIL touch_coordinate_remapper");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/tcr_pkg.sv
rtl/touch_coordinate_remapper.sv
test/touch_remap_checker.sv
test/tb_touch_coordinate_remapper.sv
